### src/cbs_pkg.sv
package cbs_pkg;

  // payload widths fixed by the bus process data
  localparam int AxisW   = 3;
  localparam int StepW   = 3;
  localparam int CfgIdxW = 2;
  localparam int CfgW    = 20;
  localparam int WindowW = 20;

  typedef enum logic [1:0] {
    OP_HOMING  = 2'd0,
    OP_CSP     = 2'd1,
    OP_ENABLE  = 2'd2,
    OP_DISABLE = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOMING_MODE = 2'd0,
    CFG_CSP_MODE    = 2'd1,
    CFG_POS_WINDOW  = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // register reset values
  localparam logic signed [7:0]  HomingModeRst = 8'sd6;
  localparam logic signed [7:0]  CspModeRst    = 8'sd8;
  localparam logic [WindowW-1:0] WindowRst     = 20'd300;

  // sequence steps
  localparam logic [StepW-1:0] Step0    = 3'd0;
  localparam logic [StepW-1:0] Step1    = 3'd1;
  localparam logic [StepW-1:0] Step2    = 3'd2;
  localparam logic [StepW-1:0] Step3    = 3'd3;
  localparam logic [StepW-1:0] Step4    = 3'd4;
  localparam logic [StepW-1:0] StepDone = 3'd5;

  // control words
  localparam logic [15:0] CwShutdown    = 16'h0006;
  localparam logic [15:0] CwSwitchOn    = 16'h0007;
  localparam logic [15:0] CwEnableOp    = 16'h000F;
  localparam logic [15:0] CwHomingStart = 16'h001F;

  // status word patterns, low and high byte
  localparam logic [7:0] SwReadyToSwitchOn = 8'h31;
  localparam logic [7:0] SwSwitchedOn      = 8'h33;
  localparam logic [7:0] SwOpEnabled       = 8'h37;
  localparam logic [7:0] SwHiHomingRun     = 8'h06;
  localparam logic [7:0] SwHiHomingDone    = 8'h16;

  typedef struct packed {
    logic [AxisW-1:0]   axis;
    op_e                opcode;
    logic               restart;
    logic [15:0]        drive_status;
    logic signed [7:0]  mode_display;
    logic signed [31:0] actual_position;
    logic signed [31:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic [AxisW-1:0]   axis_out;
    logic [15:0]        control_word;
    logic               control_valid;
    logic signed [7:0]  mode_value;
    logic               mode_valid;
    logic signed [31:0] target_value;
    logic               target_valid;
    logic [StepW-1:0]   step_out;
    logic               homing_done;
  } out_item_t;

endpackage

### src/cia402_axis_bringup_sequencer.sv
// an accepted request is registered in stage 1, then in the result register
// throughput: one request per cycle without stalls; per-axis step and last target are
//   read and written in stage 1, so back-to-back requests for one axis see fresh state
// reset: asynchronous, active low; all axis steps and last targets clear to zero,
//   mode codes return to homing 6 and csp 8, position window to 300
module cia402_axis_bringup_sequencer #(
  parameter int AXES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request side
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cbs_pkg::in_item_t             in_data_i,
  // result side
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cbs_pkg::out_item_t            out_data_o,
  // configuration writes
  input  logic                          cfg_we_i,
  input  logic [cbs_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cbs_pkg::CfgW-1:0]      cfg_data_i
);
  import cbs_pkg::*;

  // the axis field can only reach 2**AxisW slots, so storage never exceeds that
  localparam int MaxSlots = 1 << AxisW;
  localparam int NumSlots = (AXES < MaxSlots) ? AXES : MaxSlots;
  localparam int IdxW     = (NumSlots > 1) ? $clog2(NumSlots) : 1;

  // configuration registers
  logic signed [7:0]  homing_mode_q;
  logic signed [7:0]  csp_mode_q;
  logic [WindowW-1:0] window_q;

  // per-axis state
  logic [StepW-1:0]   step_q [NumSlots];
  logic signed [31:0] last_tgt_q [NumSlots];

  // input stage and result stage
  in_item_t  s1_q;
  logic      s1_valid_q;
  out_item_t out_q, out_d;
  logic      out_valid_q;

  logic       adv;
  logic       in_acc;

  // datapath signals
  logic               in_range;
  logic [IdxW-1:0]    slot;
  logic [StepW-1:0]   st_cur, st_nxt;
  logic               tgt_we;
  logic signed [31:0] tgt_val;
  logic [7:0]         sw_lo, sw_hi;
  logic signed [32:0] d_last, d_tgt;
  logic signed [33:0] w_pos, w_neg, d_last_x, d_tgt_x;
  logic               win_ok;

  //--------------------------------------------------------------------------
  // handshake: stage 1 moves into the result register when that register is
  // free or being drained; a held result does not block one more request
  //--------------------------------------------------------------------------
  assign adv        = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !adv;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_data_i;
    end
    if (adv) begin
      out_q <= out_d;
    end
  end

  //--------------------------------------------------------------------------
  // configuration port; index 3 is ignored
  //--------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      homing_mode_q <= HomingModeRst;
      csp_mode_q    <= CspModeRst;
      window_q      <= WindowRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_HOMING_MODE: homing_mode_q <= cfg_data_i[7:0];
        CFG_CSP_MODE:    csp_mode_q    <= cfg_data_i[7:0];
        CFG_POS_WINDOW:  window_q      <= cfg_data_i[WindowW-1:0];
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------------
  // per-axis lookup
  //--------------------------------------------------------------------------
  assign in_range = (AXES >= MaxSlots) || (int'(s1_q.axis) < AXES);
  assign slot     = in_range ? s1_q.axis[IdxW-1:0] : '0;
  assign sw_lo    = s1_q.drive_status[7:0];
  assign sw_hi    = s1_q.drive_status[15:8];

  // csp settle window: both differences are exact 33-bit values, compared
  // strictly against plus and minus the window
  assign d_last   = {last_tgt_q[slot][31], last_tgt_q[slot]}
                  - {s1_q.actual_position[31], s1_q.actual_position};
  assign d_tgt    = {s1_q.target_position[31], s1_q.target_position}
                  - {s1_q.actual_position[31], s1_q.actual_position};
  assign d_last_x = {d_last[32], d_last};
  assign d_tgt_x  = {d_tgt[32], d_tgt};
  assign w_pos    = {{(34-WindowW){1'b0}}, window_q};
  assign w_neg    = -w_pos;
  assign win_ok   = (d_last_x > w_neg) && (d_last_x < w_pos)
                 && (d_tgt_x > w_neg) && (d_tgt_x < w_pos);

  //--------------------------------------------------------------------------
  // sequence step and result
  //--------------------------------------------------------------------------
  always_comb begin
    // restart clears the step; steps past done behave as done
    st_cur = s1_q.restart ? Step0 : step_q[slot];
    if (st_cur > StepDone) begin
      st_cur = StepDone;
    end
    st_nxt  = st_cur;
    tgt_we  = 1'b0;
    tgt_val = '0;
    out_d   = '0;
    out_d.axis_out = s1_q.axis;

    if (in_range) begin
      unique case (s1_q.opcode)
        OP_HOMING: begin
          case (st_cur)
            Step0: begin
              out_d.control_word  = CwShutdown;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwReadyToSwitchOn) st_nxt = Step1;
            end
            Step1: begin
              out_d.mode_value = homing_mode_q;
              out_d.mode_valid = 1'b1;
              if (s1_q.mode_display == homing_mode_q) st_nxt = Step2;
            end
            Step2: begin
              out_d.control_word  = CwSwitchOn;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwSwitchedOn) st_nxt = Step3;
            end
            Step3: begin
              out_d.control_word  = CwEnableOp;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwOpEnabled && sw_hi == SwHiHomingRun) st_nxt = Step4;
            end
            Step4: begin
              out_d.control_word  = CwHomingStart;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwOpEnabled && sw_hi == SwHiHomingDone) begin
                st_nxt            = StepDone;
                out_d.homing_done = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_CSP: begin
          case (st_cur)
            Step0: begin
              out_d.control_word  = CwShutdown;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwReadyToSwitchOn) st_nxt = Step1;
            end
            Step1: begin
              out_d.mode_value = csp_mode_q;
              out_d.mode_valid = 1'b1;
              if (s1_q.mode_display == csp_mode_q) st_nxt = Step2;
            end
            Step2: begin
              // hold the drive where it stands until the target is close
              tgt_we  = 1'b1;
              tgt_val = s1_q.actual_position;
              if (win_ok) st_nxt = Step3;
            end
            Step3: begin
              out_d.control_word  = CwSwitchOn;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwSwitchedOn) st_nxt = Step4;
            end
            Step4: begin
              out_d.control_word  = CwEnableOp;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwOpEnabled) st_nxt = StepDone;
            end
            default: begin
              // running: pass the commanded target through
              tgt_we  = 1'b1;
              tgt_val = s1_q.target_position;
            end
          endcase
        end
        OP_ENABLE: begin
          case (st_cur)
            Step0: begin
              out_d.control_word  = CwShutdown;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwReadyToSwitchOn) st_nxt = Step1;
            end
            Step1: begin
              out_d.control_word  = CwSwitchOn;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwSwitchedOn) st_nxt = Step2;
            end
            Step2: begin
              out_d.control_word  = CwEnableOp;
              out_d.control_valid = 1'b1;
              if (sw_lo == SwOpEnabled) st_nxt = StepDone;
            end
            default: ;
          endcase
        end
        default: begin
          // disable: only the shutdown step is used
          if (st_cur == Step0) begin
            out_d.control_word  = CwShutdown;
            out_d.control_valid = 1'b1;
            if (sw_lo == SwReadyToSwitchOn) st_nxt = StepDone;
          end
        end
      endcase
      out_d.step_out = st_nxt;
    end

    out_d.target_value = tgt_val;
    out_d.target_valid = tgt_we;
  end

  // state update when the request leaves stage 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSlots; i++) begin
        step_q[i]     <= '0;
        last_tgt_q[i] <= '0;
      end
    end else if (adv && in_range) begin
      step_q[slot] <= st_nxt;
      if (tgt_we) begin
        last_tgt_q[slot] <= tgt_val;
      end
    end
  end

  //--------------------------------------------------------------------------
  // checks
  //--------------------------------------------------------------------------
  // at most one object is written per result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({out_data_o.control_valid, out_data_o.mode_valid,
                                out_data_o.target_valid}) <= 1)
    else $error("more than one write flagged in one result");

  // homing completion always lands on the done step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.homing_done |-> out_data_o.step_out == StepDone)
    else $error("homing done without done step");

  // a free result side never pushes back on requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("request stalled while results drain");

  // a result is registered in the cycle after stage 1 moves
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_q)
    else $error("result lost after stage 1 advanced");

endmodule

### tb/cia402_axis_bringup_sequencer_tb.sv
`timescale 1ns / 1ps

module cia402_axis_bringup_sequencer_tb;
  import cbs_pkg::*;

  localparam int NumAxes     = 8;
  // extra wait after every owed result is back
  localparam int DrainCycles = 4;
  // simulation time limit for the whole run
  localparam int TimeoutNs   = 4_000_000;

  logic clk_i;
  logic rst_ni = 1'b0;

  // request side
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i = '0;
  // result side
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;
  // register writes
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0]    cfg_data_i  = '0;

  cia402_axis_bringup_sequencer #(
    .AXES(NumAxes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // requests waiting to be driven, and results owed by the block
  in_item_t  req_q[$];
  out_item_t resp_q[$];

  // percent of cycles in which each side holds off
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned checked_count  = 0;

  // predictor copy of the register file and the per-axis state
  logic signed [7:0]  homing_code = HomingModeRst;
  logic signed [7:0]  csp_code    = CspModeRst;
  logic [WindowW-1:0] win_cfg     = WindowRst;
  logic [StepW-1:0]   step_mem [NumAxes];
  logic signed [31:0] last_mem [NumAxes];

  // what the request generator believes each axis is doing, so that most
  // requests carry the status that moves the sequence on
  logic [StepW-1:0]   plan_step [NumAxes];
  logic signed [31:0] plan_last [NumAxes];
  op_e                plan_op   [NumAxes];

  initial begin
    for (int i = 0; i < NumAxes; i++) begin
      step_mem[i]  = Step0;
      last_mem[i]  = '0;
      plan_step[i] = Step0;
      plan_last[i] = '0;
      plan_op[i]   = OP_HOMING;
    end
  end

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // predictor: one request in, the expected result out, axis state updated
  // ---------------------------------------------------------------------------
  function automatic out_item_t predict_response(in_item_t r);
    out_item_t        o;
    logic [StepW-1:0] st;
    logic [7:0]       lo;
    logic [7:0]       hi;
    longint           a;
    longint           d_last;
    longint           d_tgt;
    longint           w;
    o = '0;
    o.axis_out = r.axis;
    // axis beyond the configured count leaves everything untouched
    if (int'(r.axis) < NumAxes) begin
      if (r.restart) step_mem[r.axis] = Step0;
      st = step_mem[r.axis];
      // steps 6 and 7 behave like the finished step
      if (st > StepDone) st = StepDone;
      lo = r.drive_status[7:0];
      hi = r.drive_status[15:8];
      case (r.opcode)
        OP_HOMING: begin
          case (st)
            Step0: begin
              o.control_word  = CwShutdown;
              o.control_valid = 1'b1;
              if (lo == SwReadyToSwitchOn) st = Step1;
            end
            Step1: begin
              o.mode_value = homing_code;
              o.mode_valid = 1'b1;
              if (r.mode_display == homing_code) st = Step2;
            end
            Step2: begin
              o.control_word  = CwSwitchOn;
              o.control_valid = 1'b1;
              if (lo == SwSwitchedOn) st = Step3;
            end
            Step3: begin
              o.control_word  = CwEnableOp;
              o.control_valid = 1'b1;
              if (lo == SwOpEnabled && hi == SwHiHomingRun) st = Step4;
            end
            Step4: begin
              o.control_word  = CwHomingStart;
              o.control_valid = 1'b1;
              if (lo == SwOpEnabled && hi == SwHiHomingDone) begin
                st = StepDone;
                o.homing_done = 1'b1;
              end
            end
            default: ;
          endcase
        end
        OP_CSP: begin
          case (st)
            Step0: begin
              o.control_word  = CwShutdown;
              o.control_valid = 1'b1;
              if (lo == SwReadyToSwitchOn) st = Step1;
            end
            Step1: begin
              o.mode_value = csp_code;
              o.mode_valid = 1'b1;
              if (r.mode_display == csp_code) st = Step2;
            end
            Step2: begin
              // hold the drive where it is; differences taken without wrap
              a      = longint'(r.actual_position);
              d_last = longint'(last_mem[r.axis]) - a;
              d_tgt  = longint'(r.target_position) - a;
              w      = longint'(win_cfg);
              o.target_value = r.actual_position;
              o.target_valid = 1'b1;
              last_mem[r.axis] = r.actual_position;
              if (-w < d_last && d_last < w && -w < d_tgt && d_tgt < w) st = Step3;
            end
            Step3: begin
              o.control_word  = CwSwitchOn;
              o.control_valid = 1'b1;
              if (lo == SwSwitchedOn) st = Step4;
            end
            Step4: begin
              o.control_word  = CwEnableOp;
              o.control_valid = 1'b1;
              if (lo == SwOpEnabled) st = StepDone;
            end
            default: begin
              // running: target passes straight through
              o.target_value = r.target_position;
              o.target_valid = 1'b1;
              last_mem[r.axis] = r.target_position;
            end
          endcase
        end
        OP_ENABLE: begin
          case (st)
            Step0: begin
              o.control_word  = CwShutdown;
              o.control_valid = 1'b1;
              if (lo == SwReadyToSwitchOn) st = Step1;
            end
            Step1: begin
              o.control_word  = CwSwitchOn;
              o.control_valid = 1'b1;
              if (lo == SwSwitchedOn) st = Step2;
            end
            Step2: begin
              o.control_word  = CwEnableOp;
              o.control_valid = 1'b1;
              if (lo == SwOpEnabled) st = StepDone;
            end
            default: ;  // steps the short sequence never uses just hold
          endcase
        end
        default: begin
          if (st == Step0) begin
            o.control_word  = CwShutdown;
            o.control_valid = 1'b1;
            if (lo == SwReadyToSwitchOn) st = StepDone;
          end
        end
      endcase
      step_mem[r.axis] = st;
      o.step_out = st;
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want_v);
    $display("%0t: mismatch on %s, got %0h expected %0h (result %0d)",
             $realtime, what, got, want_v, checked_count);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // request driver: holds the payload until taken, predicts at acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_requests
    logic taken;
    taken = rst_ni && in_valid_i && !in_stall_o;
    if (taken) begin
      resp_q.push_back(predict_response(in_data_i));
      sent_count++;
    end
    if (!in_valid_i || taken) begin
      if (rst_ni && req_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data_i  <= req_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: compares each taken result with the oldest one owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (resp_q.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(out_data_o.axis_out), '0);
      end else begin
        want = resp_q.pop_front();
        checked_count++;
        if (out_data_o.axis_out !== want.axis_out)
          report_mismatch("axis_out", 32'(out_data_o.axis_out), 32'(want.axis_out));
        if (out_data_o.control_word !== want.control_word)
          report_mismatch("control_word", 32'(out_data_o.control_word),
                          32'(want.control_word));
        if (out_data_o.control_valid !== want.control_valid)
          report_mismatch("control_valid", 32'(out_data_o.control_valid),
                          32'(want.control_valid));
        if (out_data_o.mode_value !== want.mode_value)
          report_mismatch("mode_value", 32'(out_data_o.mode_value), 32'(want.mode_value));
        if (out_data_o.mode_valid !== want.mode_valid)
          report_mismatch("mode_valid", 32'(out_data_o.mode_valid), 32'(want.mode_valid));
        if (out_data_o.target_value !== want.target_value)
          report_mismatch("target_value", out_data_o.target_value, want.target_value);
        if (out_data_o.target_valid !== want.target_valid)
          report_mismatch("target_valid", 32'(out_data_o.target_valid),
                          32'(want.target_valid));
        if (out_data_o.step_out !== want.step_out)
          report_mismatch("step_out", 32'(out_data_o.step_out), 32'(want.step_out));
        if (out_data_o.homing_done !== want.homing_done)
          report_mismatch("homing_done", 32'(out_data_o.homing_done),
                          32'(want.homing_done));
      end
    end
    out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_request(logic [AxisW-1:0] ax, op_e op, logic rs, logic [15:0] sw,
                               logic signed [7:0] md, logic signed [31:0] act,
                               logic signed [31:0] tgt);
    in_item_t r;
    r.axis            = ax;
    r.opcode          = op;
    r.restart         = rs;
    r.drive_status    = sw;
    r.mode_display    = md;
    r.actual_position = act;
    r.target_position = tgt;
    req_q.push_back(r);
  endtask

  // register writes only happen with the block idle
  task automatic write_register(cfg_idx_e idx, logic [CfgW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      CFG_HOMING_MODE: homing_code = value[7:0];
      CFG_CSP_MODE:    csp_code    = value[7:0];
      CFG_POS_WINDOW:  win_cfg     = value[WindowW-1:0];
      default: ;
    endcase
  endtask

  // mode codes go in with junk above bit 7, which the block must drop
  task automatic apply_settings(logic signed [7:0] hm, logic signed [7:0] cm,
                                logic [WindowW-1:0] win);
    write_register(CFG_HOMING_MODE, {12'($urandom), hm});
    write_register(CFG_CSP_MODE, {12'($urandom), cm});
    write_register(CFG_POS_WINDOW, win);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // sender stops until every owed result is back, then the plan is resynced
  task automatic wait_drained();
    while (req_q.size() != 0 || in_valid_i || resp_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    for (int i = 0; i < NumAxes; i++) begin
      plan_step[i] = step_mem[i];
      plan_last[i] = last_mem[i];
    end
  endtask

  // builds one request, mostly the status that advances the axis sequence
  task automatic make_request(output in_item_t r);
    int unsigned      ax;
    int               w;
    bit               hit;
    logic [StepW-1:0] st;
    ax = $urandom_range(0, NumAxes - 1);
    w  = int'(win_cfg);
    r.axis            = AxisW'(ax);
    r.restart         = 1'b0;
    r.drive_status    = 16'($urandom);
    r.mode_display    = 8'($urandom);
    r.actual_position = $urandom;
    r.target_position = $urandom;
    if ((plan_step[ax] == StepDone && $urandom_range(0, 2) == 0) ||
        $urandom_range(0, 39) == 0) begin
      // fresh sequence, now and then cutting one short
      plan_op[ax]   = op_e'(2'($urandom_range(0, 3)));
      plan_step[ax] = Step0;
      r.restart     = 1'b1;
    end else if ($urandom_range(0, 29) == 0) begin
      // switch sequence mid-way with no restart
      plan_op[ax] = op_e'(2'($urandom_range(0, 3)));
    end
    r.opcode = plan_op[ax];
    st  = plan_step[ax];
    hit = ($urandom_range(0, 99) < 70);
    if (hit) begin
      case (st)
        Step0: begin
          r.drive_status[7:0] = SwReadyToSwitchOn;
          plan_step[ax] = (r.opcode == OP_DISABLE) ? StepDone : Step1;
        end
        Step1: begin
          if (r.opcode == OP_HOMING) begin
            r.mode_display = homing_code;
            plan_step[ax]  = Step2;
          end else if (r.opcode == OP_CSP) begin
            r.mode_display = csp_code;
            plan_step[ax]  = Step2;
          end else if (r.opcode == OP_ENABLE) begin
            r.drive_status[7:0] = SwSwitchedOn;
            plan_step[ax]       = Step2;
          end
        end
        Step2: begin
          if (r.opcode == OP_HOMING) begin
            r.drive_status[7:0] = SwSwitchedOn;
            plan_step[ax]       = Step3;
          end else if (r.opcode == OP_ENABLE) begin
            r.drive_status[7:0] = SwOpEnabled;
            plan_step[ax]       = StepDone;
          end
        end
        Step3: begin
          if (r.opcode == OP_HOMING) begin
            r.drive_status = {SwHiHomingRun, SwOpEnabled};
            plan_step[ax]  = Step4;
          end else if (r.opcode == OP_CSP) begin
            r.drive_status[7:0] = SwSwitchedOn;
            plan_step[ax]       = Step4;
          end
        end
        Step4: begin
          if (r.opcode == OP_HOMING) begin
            r.drive_status = {SwHiHomingDone, SwOpEnabled};
            plan_step[ax]  = StepDone;
          end else if (r.opcode == OP_CSP) begin
            r.drive_status[7:0] = SwOpEnabled;
            plan_step[ax]       = StepDone;
          end
        end
        default: ;
      endcase
    end else if (r.opcode == OP_HOMING && (st == Step3 || st == Step4) &&
                 $urandom_range(0, 1) == 1) begin
      // near miss: right low byte, the other homing high byte
      r.drive_status = {(st == Step3) ? SwHiHomingDone : SwHiHomingRun, SwOpEnabled};
    end
    // csp settling step: positions near the last target, or right on the edge
    if (r.opcode == OP_CSP && st == Step2) begin
      if (hit && w > 0) begin
        r.actual_position = plan_last[ax] + ($urandom_range(0, 1) ? 1 : -1) *
                            int'($urandom_range(0, w - 1));
        r.target_position = r.actual_position + ($urandom_range(0, 1) ? 1 : -1) *
                            int'($urandom_range(0, w - 1));
        plan_step[ax] = Step3;
      end else if ($urandom_range(0, 2) == 0) begin
        r.actual_position = plan_last[ax] + ($urandom_range(0, 1) ? w : -w);
        r.target_position = r.actual_position;
      end
      plan_last[ax] = r.actual_position;
    end else if (r.opcode == OP_CSP && st == StepDone) begin
      plan_last[ax] = r.target_position;
    end
  endtask

  task automatic run_random(int n);
    in_item_t r;
    repeat (n) begin
      make_request(r);
      req_q.push_back(r);
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // sender mostly busy, receiver mostly stalled
    send_idle_pct = 14;
    recv_idle_pct = 80;

    // homing walk on axis 0 with reset mode codes
    queue_request(0, OP_HOMING, 1, {8'h00, SwReadyToSwitchOn}, 0, 0, 0);
    queue_request(0, OP_HOMING, 0, 16'h0000, HomingModeRst - 8'sd1, 0, 0);
    queue_request(0, OP_HOMING, 0, 16'h0000, HomingModeRst, 0, 0);
    queue_request(0, OP_HOMING, 0, {8'h00, SwSwitchedOn}, 0, 0, 0);
    // wrong high byte holds step 3
    queue_request(0, OP_HOMING, 0, {SwHiHomingDone, SwOpEnabled}, 0, 0, 0);
    queue_request(0, OP_HOMING, 0, {SwHiHomingRun, SwOpEnabled}, 0, 0, 0);
    queue_request(0, OP_HOMING, 0, {SwHiHomingRun, SwOpEnabled}, 0, 0, 0);
    queue_request(0, OP_HOMING, 0, {SwHiHomingDone, SwOpEnabled}, 0, 0, 0);
    queue_request(0, OP_HOMING, 0, 16'hFFFF, 8'sh7F, 32'h7FFF_FFFF, 32'h8000_0000);

    // csp on axis 1, settling compares near the 32-bit edge
    queue_request(1, OP_CSP, 1, {8'hFF, SwReadyToSwitchOn}, 0, 0, 0);
    queue_request(1, OP_CSP, 0, 16'h0000, CspModeRst, 0, 0);
    queue_request(1, OP_CSP, 0, 16'h0000, 0, 32'h7FFF_FFF0, 32'h7FFF_FFF0);
    // wrapped target difference would look small, exact one is huge
    queue_request(1, OP_CSP, 0, 16'h0000, 0, 32'h7FFF_FFF0, 32'h8000_0000);
    // last target exactly one window away: not inside
    queue_request(1, OP_CSP, 0, 16'h0000, 0, 32'h7FFF_FEC4, 32'h7FFF_FEC4);
    queue_request(1, OP_CSP, 0, 16'h0000, 0, 32'h7FFF_FFEF, 32'h7FFF_FFFF);
    queue_request(1, OP_CSP, 0, {8'h00, SwSwitchedOn}, 0, 0, 0);
    queue_request(1, OP_CSP, 0, {8'h00, SwOpEnabled}, 0, 0, 0);
    queue_request(1, OP_CSP, 0, 16'h0000, 8'sh80, 32'h8000_0000, 32'h8000_0000);
    queue_request(1, OP_CSP, 0, 16'h0000, 0, 0, 32'h7FFF_FFFF);

    // short enable on axis 2, disable on axis 3
    queue_request(2, OP_ENABLE, 1, {8'h00, SwReadyToSwitchOn}, 0, 0, 0);
    queue_request(2, OP_ENABLE, 0, {8'h00, SwSwitchedOn}, 0, 0, 0);
    queue_request(2, OP_ENABLE, 0, {8'h00, SwOpEnabled}, 0, 0, 0);
    queue_request(2, OP_ENABLE, 0, {8'h00, SwOpEnabled}, 0, 0, 0);
    queue_request(3, OP_DISABLE, 1, {8'h00, SwReadyToSwitchOn}, 0, 0, 0);

    // steps a sequence never uses: disable at step 1, enable at step 3
    queue_request(4, OP_HOMING, 1, {8'h00, SwReadyToSwitchOn}, 0, 0, 0);
    queue_request(4, OP_DISABLE, 0, {8'h00, SwReadyToSwitchOn}, 0, 0, 0);
    queue_request(7, OP_HOMING, 1, {8'h00, SwReadyToSwitchOn}, 0, 0, 0);
    queue_request(7, OP_HOMING, 0, 16'h0000, HomingModeRst, 0, 0);
    queue_request(7, OP_HOMING, 0, {8'h00, SwSwitchedOn}, 0, 0, 0);
    queue_request(7, OP_ENABLE, 0, {8'h00, SwOpEnabled}, 0, 0, 0);
    wait_drained();

    run_random(240);

    // extreme mode codes, zero window keeps csp from ever settling
    write_register(CFG_UNUSED, 20'($urandom));
    apply_settings(8'sh80, 8'sh7F, '0);
    run_random(240);

    // receiver mostly ready, sender mostly idle
    send_idle_pct = 80;
    recv_idle_pct = 14;
    apply_settings(8'sh7F, 8'sh80, {WindowW{1'b1}});
    run_random(120);
    // sender already paused for a full drain here
    run_random(120);

    apply_settings(8'($urandom), 8'($urandom), WindowW'($urandom_range(1, 4000)));
    run_random(200);

    // no idling on either side, narrowest window that can settle
    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_settings(HomingModeRst, CspModeRst, WindowW'(1));
    run_random(200);

    $display("%0d requests sent, %0d results checked, %0d mismatches", sent_count,
             checked_count, mismatch_count);
    $display("all four sequences run under five register settings, window from 0 to max");
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TimeoutNs);
    $display("run timed out with %0d results outstanding", resp_q.size());
    $display("Verification failed");
    $finish;
  end

endmodule
